FILE: rtl/ssic_pkg.sv
`default_nettype none

package ssic_pkg;

    localparam int LIST_CAPACITY = 1024;
    localparam int ADDR_W        = $clog2(LIST_CAPACITY);
    localparam int LEN_W         = $clog2(LIST_CAPACITY + 1);
    localparam int ID_W          = 32;
    localparam int CMD_W         = 2;
    localparam int COUNT_W       = 11;

    localparam logic [CMD_W-1:0] CMD_PUSH_FIRST  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_PUSH_SECOND = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_COUNT       = CMD_W'(2);

    // controller to datapath
    typedef struct packed {
        logic push_first;
        logic push_second;
        logic walk_clear;
        logic walk_step;
        logic report;
    } ssic_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_range;
    } ssic_status_t;

endpackage

`default_nettype wire

FILE: rtl/ssic_ctrl.sv
`default_nettype none

module ssic_ctrl
    import ssic_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CMD_W-1:0] command,
    input  wire ssic_status_t     status,
    output ssic_cmd_t             cmd,
    output logic                  busy,
    output logic                  done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMPARE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        cmd.push_first  = 1'b0;
        cmd.push_second = 1'b0;
        cmd.walk_clear  = 1'b0;
        cmd.walk_step   = 1'b0;
        cmd.report      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.push_first  = (command == CMD_PUSH_FIRST);
                    cmd.push_second = (command == CMD_PUSH_SECOND);
                    if (command == CMD_COUNT)
                    begin
                        cmd.walk_clear = 1'b1;
                        state_next     = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                // store data for the current pointers is read this cycle
                if (status.in_range)
                begin
                    state_next = ST_COMPARE;
                end
                else
                begin
                    cmd.report = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_COMPARE:
            begin
                cmd.walk_step = 1'b1;
                state_next    = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done strobe longer than one cycle");

    a_done_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done_reg)
        else $error("busy dropped without a result");

    a_step_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> $past(status.in_range))
        else $error("walk step without pointers in range");

endmodule

`default_nettype wire

FILE: rtl/ssic_datapath.sv
`default_nettype none

module ssic_datapath
    import ssic_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ssic_cmd_t          cmd,
    input  wire logic [ID_W-1:0]    item_id,
    output ssic_status_t            status,
    output logic [COUNT_W-1:0]      match_count,
    output logic                    overflowed
);

    logic [ID_W-1:0]    first_mem  [LIST_CAPACITY];
    logic [ID_W-1:0]    second_mem [LIST_CAPACITY];

    logic [ID_W-1:0]    first_rd_reg;
    logic [ID_W-1:0]    second_rd_reg;
    logic [LEN_W-1:0]   first_len_reg;
    logic [LEN_W-1:0]   second_len_reg;
    logic [LEN_W-1:0]   first_ptr_reg;
    logic [LEN_W-1:0]   second_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               overflow_reg;
    logic [COUNT_W-1:0] match_count_reg;
    logic               overflowed_reg;

    logic               first_full;
    logic               second_full;
    logic               ids_equal;
    logic               first_less;

    assign first_full  = (first_len_reg  == LEN_W'(LIST_CAPACITY));
    assign second_full = (second_len_reg == LEN_W'(LIST_CAPACITY));
    assign ids_equal   = (first_rd_reg == second_rd_reg);
    assign first_less  = (first_rd_reg <  second_rd_reg);

    assign status.in_range = (first_ptr_reg < first_len_reg)
                          && (second_ptr_reg < second_len_reg);

    assign match_count = match_count_reg;
    assign overflowed  = overflowed_reg;

    // stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.push_first && !first_full)
        begin
            first_mem[first_len_reg[ADDR_W-1:0]] <= item_id;
        end
        if (cmd.push_second && !second_full)
        begin
            second_mem[second_len_reg[ADDR_W-1:0]] <= item_id;
        end
        first_rd_reg  <= first_mem[first_ptr_reg[ADDR_W-1:0]];
        second_rd_reg <= second_mem[second_ptr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            match_count_reg <= count_reg;
            overflowed_reg  <= overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            first_ptr_reg  <= '0;
            second_ptr_reg <= '0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.push_first)
            begin
                if (first_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    first_len_reg <= first_len_reg + LEN_W'(1);
                end
            end
            if (cmd.push_second)
            begin
                if (second_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    second_len_reg <= second_len_reg + LEN_W'(1);
                end
            end
            if (cmd.walk_clear)
            begin
                first_ptr_reg  <= '0;
                second_ptr_reg <= '0;
                count_reg      <= '0;
            end
            if (cmd.walk_step)
            begin
                if (ids_equal)
                begin
                    count_reg      <= count_reg + COUNT_W'(1);
                    first_ptr_reg  <= first_ptr_reg + LEN_W'(1);
                    second_ptr_reg <= second_ptr_reg + LEN_W'(1);
                end
                else if (first_less)
                begin
                    first_ptr_reg <= first_ptr_reg + LEN_W'(1);
                end
                else
                begin
                    second_ptr_reg <= second_ptr_reg + LEN_W'(1);
                end
            end
            if (cmd.report)
            begin
                first_len_reg  <= '0;
                second_len_reg <= '0;
                overflow_reg   <= 1'b0;
            end
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= LEN_W'(LIST_CAPACITY))
        && (second_len_reg <= LEN_W'(LIST_CAPACITY)))
        else $error("list length beyond capacity");

    a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_first && first_full) |=> overflow_reg)
        else $error("dropped push did not set overflow");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> (first_len_reg == '0) && (second_len_reg == '0) && !overflow_reg)
        else $error("lists not cleared after count");

endmodule

`default_nettype wire

FILE: rtl/sorted_set_intersection_count_unit.sv
`default_nettype none
// Push requests (command 0 or 1) leave busy low, so pushes may arrive back to
// back. A count request (command 2) walks both lists: each walk step is a
// store read, then a compare, with steps <= max(0, la + lb - 1); done pulses
// once either pointer reaches the end of its list. The result appears on
// match_count/overflowed with done and holds until the next count completes;
// the receiver cannot stall. rst_n (async, active low) empties both lists.

module sorted_set_intersection_count_unit
    import ssic_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [CMD_W-1:0]   command,
    input  wire logic [ID_W-1:0]    item_id,
    output logic                    done,
    output logic [COUNT_W-1:0]      match_count,
    output logic                    overflowed
);

    ssic_cmd_t    cmd;
    ssic_status_t status;

    // Controller: decode requests, sequence the merge walk, pulse done.
    ssic_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    // Datapath: hold both lists, their lengths, walk pointers and the
    // running match count; drop pushes to a full list and flag them.
    ssic_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item_id     (item_id),
        .status      (status),
        .match_count (match_count),
        .overflowed  (overflowed)
    );

endmodule

`default_nettype wire
